[hw/rtl/psc_pkg.sv]
// psc_pkg: shared types, constants and tables for the point steering controller.
// Used by psc_cordic, point_steering_controller and psc_checker; no dependencies.

package psc_pkg;

  // Sizing of the iterative CORDIC and the waypoint counter
  localparam int CORDIC_STEPS = 16;   // 8..30
  localparam int INDEX_BITS   = 16;   // 4..32
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  // Arctangent table, atan(2^-i) in 32-bit binary angle units
  localparam int ATAN_ENTRIES = 30;
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // Datapath widths: x/y carry a 33-bit offset scaled by 2^24 plus CORDIC growth
  localparam int PRESCALE = 24;
  localparam int XY_W     = 62;
  localparam int Z_W      = 34;
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 32;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int DIST_W   = 34;

  // Fixed-point constants
  localparam logic [31:0] INV_K2_Q30 = 32'd395948877;   // 1/K^2 gain correction
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;  // 2*pi in Q29
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

  // Stream word widths
  localparam int IN_W  = 144;
  localparam int OUT_W = 80;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIN_GAIN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ANG_GAIN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [15:0] LIN_GAIN_RST  = 16'd128;    // 0.5
  localparam logic [15:0] ANG_GAIN_RST  = 16'd1024;   // 4.0
  localparam logic [30:0] THRESHOLD_RST = 31'd6554;   // 0.1 m

  // Control sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT,
    S_VEC_LOAD,
    S_VEC,
    S_MUL_LO,
    S_MUL_HI,
    S_DIST,
    S_MUL_SPD,
    S_MUL_RAD,
    S_MUL_RATE,
    S_FIN
  } psc_state_t;

  // Command to the CORDIC engine
  typedef struct packed {
    logic load;        // capture x/y/z and start a pass
    logic vectoring;   // 1: drive y to zero, 0: drive z to zero
  } psc_cordic_ctl_t;

endpackage

[hw/rtl/point_steering_controller.sv]
// point_steering_controller: go-to-point steering, CORDIC rotate/vector plus gain scaling.
// Depends on psc_pkg and psc_cordic.

// One word in gives one word out. An accepted tick rotates the goal offset into
// the robot frame, then measures bearing and distance, on a single iterative
// CORDIC engine (one micro-rotation per clock, CORDIC_STEPS per pass, two passes);
// a single 34x32 multiplier then applies the 1/K^2 correction, the linear gain,
// the radian scale and the angular gain in five sequenced products. The vectoring
// pass is skipped when the offset is zero; in_tready returns in the same cycle
// that the result appears in the output register, which holds it until
// taken. Register writes on the cfg port are applied at once and must only be
// made while no tick is in flight.

module point_steering_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  // goal_x[31:0] goal_y[63:32] robot_x[95:64] robot_y[127:96] heading[143:128]
  input  logic [psc_pkg::IN_W-1:0]         in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // angular_rate[31:0] forward_speed[62:32] reached[63] waypoint_number[79:64]
  output logic [psc_pkg::OUT_W-1:0]        out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  logic [psc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  psc_pkg::psc_state_t                state_r, state_nxt;

  logic [15:0]                        lin_gain_r, ang_gain_r;
  logic [30:0]                        threshold_r;
  logic [psc_pkg::INDEX_BITS-1:0]     wp_r, wp_nxt;

  logic                               out_tvalid_r;
  logic [31:0]                        rate_r;
  logic [30:0]                        speed_out_r;
  logic                               reached_out_r;
  logic [15:0]                        wp_out_r;

  logic [psc_pkg::XY_W-2:0]           m_r;
  logic [31:0]                        mag_r;
  logic                               bneg_r;
  logic [31:0]                        lohi_r;
  logic [psc_pkg::DIST_W-1:0]         dist_r;
  logic [30:0]                        speed_r;
  logic                               reached_r;
  logic [psc_pkg::PROD_W-1:0]         prod_r;

  psc_pkg::psc_cordic_ctl_t           cor_ctl;
  logic signed [psc_pkg::XY_W-1:0]    cor_x_in, cor_y_in, cor_x, cor_y;
  logic signed [psc_pkg::Z_W-1:0]     cor_z_in, cor_z;
  logic                               cor_done;

  logic [psc_pkg::MUL_A_W-1:0]        mul_a;
  logic [psc_pkg::MUL_B_W-1:0]        mul_b;
  logic [psc_pkg::PROD_W-1:0]         mul_p;

  logic                               in_acc, out_free;
  logic signed [32:0]                 dx, dy;
  logic signed [psc_pkg::XY_W-1:0]    x0, y0;
  logic [15:0]                        hneg;
  logic [31:0]                        zturn;
  logic                               flip;
  logic                               vec_zero, vec_neg;
  logic [31:0]                        ang;
  logic [psc_pkg::DIST_W-1:0]         dist_nxt;
  logic [25:0]                        rm;

  assign in_acc   = in_tvalid & in_tready;
  assign out_free = ~out_tvalid_r | out_tready;

  // Offset, scaled up, and the reduced -heading angle for the first pass
  always_comb begin
    dx    = {in_tdata[31], in_tdata[31:0]} - {in_tdata[95], in_tdata[95:64]};
    dy    = {in_tdata[63], in_tdata[63:32]} - {in_tdata[127], in_tdata[127:96]};
    x0    = {{(psc_pkg::XY_W-33-psc_pkg::PRESCALE){dx[32]}}, dx,
             {psc_pkg::PRESCALE{1'b0}}};
    y0    = {{(psc_pkg::XY_W-33-psc_pkg::PRESCALE){dy[32]}}, dy,
             {psc_pkg::PRESCALE{1'b0}}};
    hneg  = 16'd0 - in_tdata[143:128];
    zturn = {hneg, 16'd0};
    // outside [-90, 90) degrees: take a half turn off and negate the vector
    flip  = zturn[31] ^ zturn[30];
  end

  // Vectoring setup from the rotated vector
  assign vec_zero = (cor_x == '0) && (cor_y == '0);
  assign vec_neg  = cor_x[psc_pkg::XY_W-1];
  assign ang      = cor_z[31:0];

  // Sequencer: next state, engine command and multiplier operands
  always_comb begin
    state_nxt = state_r;
    cor_ctl   = '0;
    cor_x_in  = x0;
    cor_y_in  = y0;
    cor_z_in  = {{(psc_pkg::Z_W-31){zturn[31] ^ flip}}, zturn[30:0]};
    mul_a     = '0;
    mul_b     = '0;
    in_tready = 1'b0;
    case (state_r)
      psc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (flip) begin
          cor_x_in = -x0;
          cor_y_in = -y0;
        end
        if (in_tvalid) begin
          cor_ctl.load = 1'b1;
          state_nxt    = psc_pkg::S_ROT;
        end
      end
      psc_pkg::S_ROT: begin
        if (cor_done) state_nxt = psc_pkg::S_VEC_LOAD;
      end
      psc_pkg::S_VEC_LOAD: begin
        cor_x_in = vec_neg ? -cor_x : cor_x;
        cor_y_in = vec_neg ? -cor_y : cor_y;
        cor_z_in = vec_neg ? {{(psc_pkg::Z_W-32){1'b0}}, psc_pkg::HALF_TURN} : '0;
        if (vec_zero) begin
          state_nxt = psc_pkg::S_MUL_LO;
        end else begin
          cor_ctl.load      = 1'b1;
          cor_ctl.vectoring = 1'b1;
          state_nxt         = psc_pkg::S_VEC;
        end
      end
      psc_pkg::S_VEC: begin
        if (cor_done) state_nxt = psc_pkg::S_MUL_LO;
      end
      psc_pkg::S_MUL_LO: begin
        mul_a     = psc_pkg::MUL_A_W'(m_r[31:0]);
        mul_b     = psc_pkg::INV_K2_Q30;
        state_nxt = psc_pkg::S_MUL_HI;
      end
      psc_pkg::S_MUL_HI: begin
        mul_a     = psc_pkg::MUL_A_W'(m_r[psc_pkg::XY_W-2:32]);
        mul_b     = psc_pkg::INV_K2_Q30;
        state_nxt = psc_pkg::S_DIST;
      end
      psc_pkg::S_DIST: begin
        state_nxt = psc_pkg::S_MUL_SPD;
      end
      psc_pkg::S_MUL_SPD: begin
        mul_a     = dist_r;
        mul_b     = psc_pkg::MUL_B_W'(lin_gain_r);
        state_nxt = psc_pkg::S_MUL_RAD;
      end
      psc_pkg::S_MUL_RAD: begin
        mul_a     = psc_pkg::MUL_A_W'(mag_r);
        mul_b     = psc_pkg::TWO_PI_Q29;
        state_nxt = psc_pkg::S_MUL_RATE;
      end
      psc_pkg::S_MUL_RATE: begin
        // radians in Q16.16, below 2^18
        mul_a     = psc_pkg::MUL_A_W'(prod_r[62:45]);
        mul_b     = psc_pkg::MUL_B_W'(ang_gain_r);
        state_nxt = psc_pkg::S_FIN;
      end
      psc_pkg::S_FIN: begin
        if (out_free) state_nxt = psc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = psc_pkg::S_IDLE;
      end
    endcase
  end

  // Shared multiplier
  assign mul_p = psc_pkg::PROD_W'(mul_a) * psc_pkg::PROD_W'(mul_b);

  // Distance: floor(m * C / 2^54) from the two partial products
  assign dist_nxt = psc_pkg::DIST_W'((prod_r + psc_pkg::PROD_W'(lohi_r)) >> 22);

  // Turn rate magnitude stays below 2^26, so only the sign is applied
  assign rm = prod_r[33:8];

  assign wp_nxt = reached_r ? wp_r + psc_pkg::INDEX_BITS'(1) : wp_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psc_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
      wp_r         <= '0;
      lin_gain_r   <= psc_pkg::LIN_GAIN_RST;
      ang_gain_r   <= psc_pkg::ANG_GAIN_RST;
      threshold_r  <= psc_pkg::THRESHOLD_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == psc_pkg::S_FIN && out_free) begin
        out_tvalid_r <= 1'b1;
        wp_r         <= wp_nxt;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          psc_pkg::CFG_LIN_GAIN:  lin_gain_r  <= cfg_wdata[15:0];
          psc_pkg::CFG_ANG_GAIN:  ang_gain_r  <= cfg_wdata[15:0];
          psc_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      psc_pkg::S_VEC_LOAD: begin
        if (vec_zero) begin
          m_r    <= '0;
          mag_r  <= '0;
          bneg_r <= 1'b0;
        end
      end
      psc_pkg::S_VEC: begin
        bneg_r <= ang[31];
        mag_r  <= ang[31] ? 32'd0 - ang : ang;
        m_r    <= cor_x[psc_pkg::XY_W-1] ? '0 : cor_x[psc_pkg::XY_W-2:0];
      end
      psc_pkg::S_MUL_LO: begin
        prod_r <= mul_p;
      end
      psc_pkg::S_MUL_HI: begin
        lohi_r <= prod_r[63:32];
        prod_r <= mul_p;
      end
      psc_pkg::S_DIST: begin
        dist_r <= dist_nxt;
      end
      psc_pkg::S_MUL_SPD: begin
        reached_r <= dist_r < psc_pkg::DIST_W'(threshold_r);
        prod_r    <= mul_p;
      end
      psc_pkg::S_MUL_RAD: begin
        speed_r <= (|prod_r[psc_pkg::PROD_W-1:39]) ? 31'h7fff_ffff : prod_r[38:8];
        prod_r  <= mul_p;
      end
      psc_pkg::S_MUL_RATE: begin
        prod_r <= mul_p;
      end
      psc_pkg::S_FIN: begin
        if (out_free) begin
          rate_r        <= bneg_r ? 32'd0 - 32'(rm) : 32'(rm);
          speed_out_r   <= speed_r;
          reached_out_r <= reached_r;
          wp_out_r      <= 16'(wp_nxt);
        end
      end
      default: ;
    endcase
  end

  psc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cor_ctl),
    .x_in  (cor_x_in),
    .y_in  (cor_y_in),
    .z_in  (cor_z_in),
    .x_out (cor_x),
    .y_out (cor_y),
    .z_out (cor_z),
    .done  (cor_done)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {wp_out_r, reached_out_r, speed_out_r, rate_r};

endmodule

[hw/rtl/psc_cordic.sv]
// psc_cordic: iterative CORDIC engine, one micro-rotation per cycle, rotation or vectoring.
// Depends on psc_pkg (widths, step count, arctangent table, control struct).

module psc_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psc_pkg::psc_cordic_ctl_t      ctl,
  input  logic signed [psc_pkg::XY_W-1:0] x_in,
  input  logic signed [psc_pkg::XY_W-1:0] y_in,
  input  logic signed [psc_pkg::Z_W-1:0]  z_in,
  output logic signed [psc_pkg::XY_W-1:0] x_out,
  output logic signed [psc_pkg::XY_W-1:0] y_out,
  output logic signed [psc_pkg::Z_W-1:0]  z_out,
  output logic                          done
);

  logic                                running_r;
  logic                                done_r;
  logic                                mode_r;
  logic [psc_pkg::STEP_W-1:0]          step_r;
  logic signed [psc_pkg::XY_W-1:0]     x_r, y_r;
  logic signed [psc_pkg::Z_W-1:0]      z_r;

  logic signed [psc_pkg::XY_W-1:0]     sh_x, sh_y, x_nxt, y_nxt;
  logic signed [psc_pkg::Z_W-1:0]      z_nxt, atan_z;
  logic                                cw;
  logic                                last_step;

  // Shared step unit: shift, add/sub, angle table lookup
  always_comb begin
    sh_x   = x_r >>> step_r;
    sh_y   = y_r >>> step_r;
    atan_z = signed'({{(psc_pkg::Z_W-32){1'b0}},
                      psc_pkg::ATAN_TAB[psc_pkg::ATAN_IDX_W'(step_r)]});
    // vectoring turns toward y=0, rotation toward z=0
    cw = mode_r ? y_r[psc_pkg::XY_W-1] : ~z_r[psc_pkg::Z_W-1];
    if (cw) begin
      x_nxt = x_r - sh_y;
      y_nxt = y_r + sh_x;
      z_nxt = z_r - atan_z;
    end else begin
      x_nxt = x_r + sh_y;
      y_nxt = y_r - sh_x;
      z_nxt = z_r + atan_z;
    end
  end

  assign last_step = (step_r == psc_pkg::STEP_W'(psc_pkg::CORDIC_STEPS - 1));

  // Pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      done_r <= running_r & last_step;
      if (ctl.load) begin
        running_r <= 1'b1;
        step_r    <= '0;
      end else if (running_r) begin
        step_r <= step_r + psc_pkg::STEP_W'(1);
        if (last_step) running_r <= 1'b0;
      end
    end
  end

  // Vector and angle registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r    <= x_in;
      y_r    <= y_in;
      z_r    <= z_in;
      mode_r <= ctl.vectoring;
    end else if (running_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign done  = done_r;

endmodule

[hw/rtl/psc_checker.sv]
// psc_checker: port-level assertions for point_steering_controller, bound to the top.
// Depends on psc_pkg for word widths.

module psc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic [psc_pkg::IN_W-1:0]      in_tdata,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [psc_pkg::OUT_W-1:0]     out_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready
);

  // An accepted word keeps the input closed for the next cycles
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted word");

  a_busy_two_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##2 !in_tready)
    else $error("input ready two cycles after an accepted word");

  // A new result is only raised when the input side was closed just before
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while input was open");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result word changed or dropped while stalled");

endmodule

bind point_steering_controller psc_checker u_psc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
